// ----- rtl/core/max_ones_rectangle_area_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the maximal rectangle block.
// ----------------------------------------------------------------------------
`ifndef MAX_ONES_RECTANGLE_AREA_MACROS_SVH
`define MAX_ONES_RECTANGLE_AREA_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MORA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MORA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/mora_pkg.sv -----
// ----------------------------------------------------------------------------
// mora_pkg
// Constants and types shared by the maximal rectangle block.
// ----------------------------------------------------------------------------
package mora_pkg;

    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_ROWS    = 256;

    localparam int ROW_WIDTH_W     = 9;
    localparam int ROW_WIDTH_RESET = 256;
    localparam int AREA_W          = 17;
    localparam int ROWS_W          = 9;
    localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;

    // Per-column pass control issued by the sequencer.
    typedef struct packed {
        logic issue;
        logic left_pass;
        logic first;
    } mora_pass_t;

endpackage

// ----- rtl/core/mora_row_buf.sv -----
// ----------------------------------------------------------------------------
// mora_row_buf
// Row pixel store: written from the input channel, read by the column passes.
// ----------------------------------------------------------------------------
module mora_row_buf #(
    parameter int MAX_COLS = mora_pkg::DEF_MAX_COLS,
    parameter int COL_W    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic             wr_data,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output logic             rd_data
);
    import mora_pkg::*;

    logic mem [MAX_COLS];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/mora_col_proc.sv -----
// ----------------------------------------------------------------------------
// mora_col_proc
// Column state memory with read-modify-write datapath for both row passes
// and the running best area.
// ----------------------------------------------------------------------------
module mora_col_proc #(
    parameter int MAX_COLS = mora_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mora_pkg::DEF_MAX_ROWS,
    parameter int COL_W    = 8,
    parameter int CNT_W    = 9,
    parameter int HT_W     = 9
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mora_pkg::mora_pass_t         pass,
    input  logic [COL_W-1:0]             addr,
    input  logic                         row_bit,
    input  logic [CNT_W-1:0]             width,
    input  logic [CNT_W-1:0]             filled,
    input  logic [CNT_W-1:0]             fill_mark,
    input  logic                         clear,
    output logic [mora_pkg::AREA_W-1:0]  best_area
);
    import mora_pkg::*;

    localparam int WORD_W = HT_W + 2 * COL_W;
    localparam int SPAN_W = COL_W + 1;
    localparam int PROD_W = SPAN_W + HT_W;
    localparam int EXT_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

    logic [WORD_W-1:0] mem [MAX_COLS];
    logic [WORD_W-1:0] q_reg;

    mora_pass_t        pass_d_reg;
    logic [COL_W-1:0]  addr_d_reg;
    logic [COL_W-1:0]  rb_reg;
    logic [COL_W-1:0]  rb_next;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;
    logic [AREA_W-1:0] best_reg;

    logic              entry_ok;
    logic              one;
    logic [HT_W-1:0]   height;
    logic [COL_W-1:0]  left;
    logic [COL_W-1:0]  right;
    logic [HT_W-1:0]   height_new;
    logic [COL_W-1:0]  left_new;
    logic [COL_W-1:0]  right_new;
    logic [COL_W-1:0]  rb_cur;
    logic [SPAN_W-1:0] span;
    logic [PROD_W-1:0] prod_next;
    logic              prod_take;
    logic [EXT_W-1:0]  prod_ext;
    logic [AREA_W-1:0] area_sat;

    always_ff @(posedge aclk) begin
        if (pass.issue) begin
            q_reg <= mem[addr];
        end
        if (pass_d_reg.issue) begin
            mem[addr_d_reg] <= {height_new, left_new, right_new};
        end
    end

    always_comb begin
        entry_ok = pass_d_reg.left_pass || (CNT_W'(addr_d_reg) < fill_mark);
        one      = row_bit && (CNT_W'(addr_d_reg) < filled);
        if (entry_ok) begin
            height = q_reg[WORD_W-1 -: HT_W];
            left   = q_reg[2*COL_W-1 -: COL_W];
            right  = q_reg[COL_W-1:0];
        end else begin
            height = '0;
            left   = '0;
            right  = COL_W'(MAX_COLS - 1);
        end

        height_new = height;
        left_new   = left;
        right_new  = right;
        prod_take  = 1'b0;

        if (pass_d_reg.left_pass) begin
            rb_cur  = pass_d_reg.first ? '0 : rb_reg;
            rb_next = rb_cur;
            if (one) begin
                height_new = (HT_W'(height) < HT_W'(MAX_ROWS)) ? height + 1'b1 : height;
                left_new   = (left < rb_cur) ? rb_cur : left;
                prod_take  = 1'b1;
            end else begin
                height_new = '0;
                left_new   = '0;
                rb_next    = addr_d_reg + 1'b1;
            end
        end else begin
            rb_cur  = pass_d_reg.first ? COL_W'(width - 1'b1) : rb_reg;
            rb_next = rb_cur;
            if (one) begin
                right_new = (right > rb_cur) ? rb_cur : right;
            end else begin
                right_new = COL_W'(width - 1'b1);
                rb_next   = addr_d_reg - 1'b1;
            end
        end

        span      = {1'b0, right_new} - {1'b0, left_new} + 1'b1;
        prod_next = PROD_W'(span) * PROD_W'(height_new);

        prod_ext  = EXT_W'(prod_reg);
        area_sat  = (prod_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_d_reg     <= '0;
            prod_valid_reg <= 1'b0;
            best_reg       <= '0;
        end else begin
            pass_d_reg     <= pass;
            prod_valid_reg <= pass_d_reg.issue && prod_take;
            if (clear) begin
                best_reg <= '0;
            end else if (prod_valid_reg && (area_sat > best_reg)) begin
                best_reg <= area_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_d_reg <= addr;
        prod_reg   <= prod_next;
        if (pass_d_reg.issue) begin
            rb_reg <= rb_next;
        end
    end

    assign best_area = best_reg;

endmodule

// ----- rtl/core/max_ones_rectangle_area.sv -----
// ----------------------------------------------------------------------------
// max_ones_rectangle_area
// Largest all-ones rectangle over a binary image streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one pixel per item, with s_last_of_frame on the final
//   pixel of the image. Output channel m_*: one item per frame carrying the
//   largest rectangle area and the number of rows seen.
//   Configuration channel cfg_*: row width, 1 to MAX_COLS pixels (0 acts as
//   1, larger values as MAX_COLS); write only between items.
//   Flow: s_ready is high only in the idle state, where pixels that do not
//   end a row are taken. A pixel that ends a row (or the frame) starts two
//   passes over the column memory, right to left and then left to right,
//   one read and one write-back per column each; no pixel is taken until
//   both passes and the drain states are done. The result is registered
//   in the emit state. A partial last row is padded with zeros.
//   Reset: synchronous, active low; pixel/row counters and best area clear,
//   row width returns to 256. No memory clearing pass is needed.
//   Stall: a pending result is held in the output register while the next
//   frame streams in; only a following frame end waits for m_ready.
// ----------------------------------------------------------------------------
`include "max_ones_rectangle_area_macros.svh"

module max_ones_rectangle_area #(
    parameter int MAX_COLS = mora_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mora_pkg::DEF_MAX_ROWS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mora_pkg::ROW_WIDTH_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_pixel,
    input  logic                             s_last_of_frame,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mora_pkg::AREA_W-1:0]      m_max_area,
    output logic [mora_pkg::ROWS_W-1:0]      m_rows_in_frame
);
    import mora_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int HT_W  = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RPASS  = 7'b0000010,
        ST_GAP    = 7'b0000100,
        ST_LPASS  = 7'b0001000,
        ST_DRAIN1 = 7'b0010000,
        ST_DRAIN2 = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t                  state_reg;
    logic [ROW_WIDTH_W-1:0]  row_width_reg;
    logic [CNT_W-1:0]        cc_reg;
    logic [CNT_W-1:0]        w_reg;
    logic [CNT_W-1:0]        filled_reg;
    logic [CNT_W-1:0]        hw_reg;
    logic [COL_W-1:0]        addr_reg;
    logic [HT_W-1:0]         row_count_reg;
    logic                    emit_reg;
    logic                    m_valid_reg;
    logic [AREA_W-1:0]       m_area_reg;
    logic [ROWS_W-1:0]       m_rows_reg;

    logic [CMP_W-1:0]        width_ext;
    logic [CNT_W-1:0]        eff_width;
    logic [CNT_W-1:0]        cc_new;
    logic                    s_accept;
    logic                    out_free;
    logic                    emit_now;
    logic                    row_bit;
    logic [AREA_W-1:0]       best_area;
    mora_pass_t              pass;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_now  = (state_reg == ST_EMIT) && out_free;
    assign cc_new    = cc_reg + 1'b1;

    always_comb begin
        width_ext = CMP_W'(row_width_reg);
        if (width_ext == '0) begin
            eff_width = CNT_W'(1);
        end else if (width_ext > CMP_W'(MAX_COLS)) begin
            eff_width = CNT_W'(MAX_COLS);
        end else begin
            eff_width = CNT_W'(width_ext);
        end
    end

    always_comb begin
        pass.issue     = (state_reg == ST_RPASS) || (state_reg == ST_LPASS);
        pass.left_pass = (state_reg == ST_LPASS);
        if (state_reg == ST_RPASS) begin
            pass.first = (CNT_W'(addr_reg) == w_reg - 1'b1);
        end else begin
            pass.first = (addr_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_width_reg <= ROW_WIDTH_W'(ROW_WIDTH_RESET);
            cc_reg        <= '0;
            hw_reg        <= '0;
            row_count_reg <= '0;
            emit_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                row_width_reg <= cfg_data;
            end
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        emit_reg <= s_last_of_frame;
                        if ((cc_new >= eff_width) || s_last_of_frame) begin
                            state_reg <= ST_RPASS;
                        end else begin
                            cc_reg <= cc_new;
                        end
                    end
                end
                ST_RPASS: begin
                    if (addr_reg == '0) begin
                        state_reg <= ST_GAP;
                    end
                end
                ST_GAP: begin
                    state_reg <= ST_LPASS;
                end
                ST_LPASS: begin
                    if (CNT_W'(addr_reg) == w_reg - 1'b1) begin
                        state_reg <= ST_DRAIN1;
                    end
                end
                ST_DRAIN1: begin
                    state_reg <= ST_DRAIN2;
                end
                ST_DRAIN2: begin
                    cc_reg <= '0;
                    if (w_reg > hw_reg) begin
                        hw_reg <= w_reg;
                    end
                    if (HT_W'(row_count_reg) < HT_W'(MAX_ROWS)) begin
                        row_count_reg <= row_count_reg + 1'b1;
                    end
                    state_reg <= emit_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        cc_reg        <= '0;
                        hw_reg        <= '0;
                        row_count_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            w_reg      <= eff_width;
            filled_reg <= cc_new;
            addr_reg   <= COL_W'(eff_width - 1'b1);
        end else if (state_reg == ST_RPASS) begin
            addr_reg <= addr_reg - 1'b1;
        end else if (state_reg == ST_GAP) begin
            addr_reg <= '0;
        end else if (state_reg == ST_LPASS) begin
            addr_reg <= addr_reg + 1'b1;
        end
        if (emit_now) begin
            m_area_reg <= best_area;
            m_rows_reg <= ROWS_W'(row_count_reg);
        end
    end

    mora_row_buf #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_row_buf (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (cc_reg[COL_W-1:0]),
        .wr_data (s_pixel),
        .rd_en   (pass.issue),
        .rd_addr (addr_reg),
        .rd_data (row_bit)
    );

    mora_col_proc #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .COL_W    (COL_W),
        .CNT_W    (CNT_W),
        .HT_W     (HT_W)
    ) u_col_proc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pass      (pass),
        .addr      (addr_reg),
        .row_bit   (row_bit),
        .width     (w_reg),
        .filled    (filled_reg),
        .fill_mark (hw_reg),
        .clear     (emit_now),
        .best_area (best_area)
    );

    assign m_valid         = m_valid_reg;
    assign m_max_area      = m_area_reg;
    assign m_rows_in_frame = m_rows_reg;

    `MORA_ASSERT_NOW(a_col_in_range, aclk, aresetn, (state_reg == ST_IDLE), (cc_reg < CNT_W'(MAX_COLS)))
    `MORA_ASSERT_NOW(a_pass_addr, aclk, aresetn, pass.issue, (CNT_W'(addr_reg) < w_reg))
    `MORA_ASSERT_NEXT(a_no_emit, aclk, aresetn, ((state_reg == ST_DRAIN2) && !emit_reg), (state_reg == ST_IDLE))
    `MORA_ASSERT_NEXT(a_emit_clear, aclk, aresetn, emit_now, (m_valid && (cc_reg == '0) && (hw_reg == '0)))

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams binary frames through the maximal rectangle block and checks the
// reported area and row count of every frame against an in-bench predictor.
// Directed frames cover single pixels, width extremes, partial rows, width
// changes inside a frame, tall frames and one long output hold-off; random
// frames follow, with random input bursts and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import mora_pkg::*;

    localparam int MAX_COLS      = DEF_MAX_COLS;
    localparam int MAX_ROWS      = DEF_MAX_ROWS;
    localparam int AREA_LIMIT    = int'(AREA_MAX);
    localparam int SETTLE_CYCLES = 3 * MAX_COLS + 32;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 250;
    localparam int RANDOM_FRAMES = 8;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [ROWS_W-1:0] rows;
    } frame_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PATTERN
    } ready_mode_t;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [ROW_WIDTH_W-1:0] cfg_data        = '0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic                   s_pixel         = 1'b0;
    logic                   s_last_of_frame = 1'b0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic [AREA_W-1:0]      m_max_area;
    logic [ROWS_W-1:0]      m_rows_in_frame;

    frame_result_t expected_areas[$];
    int errors      = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int frames_sent = 0;

    int burst_left = 0;
    bit steady     = 1'b1;

    int          hold_req   = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          mode_left  = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    // Predictor state.
    logic [ROW_WIDTH_W-1:0] width_reg;
    bit row_bits   [MAX_COLS];
    int col_height [MAX_COLS];
    int left_col   [MAX_COLS];
    int right_col  [MAX_COLS];
    int best_area;
    int col_fill;
    int row_total;

    max_ones_rectangle_area u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .s_last_of_frame (s_last_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_max_area      (m_max_area),
        .m_rows_in_frame (m_rows_in_frame)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int clamp_width(int value);
        if (value == 0) return 1;
        if (value > MAX_COLS) return MAX_COLS;
        return value;
    endfunction

    function automatic void clear_frame();
        foreach (col_height[j]) begin
            col_height[j] = 0;
            left_col[j]   = 0;
            right_col[j]  = MAX_COLS - 1;
        end
        best_area = 0;
        col_fill  = 0;
        row_total = 0;
    endfunction

    function automatic void fold_row(int w, int filled);
        int bound;
        bit one;
        bit [31:0] span;
        longint area;
        bound = w - 1;
        for (int j = w - 1; j >= 0; j--) begin
            one = (j < filled) && row_bits[j];
            if (one) begin
                if (right_col[j] > bound) right_col[j] = bound;
            end else begin
                bound        = j - 1;
                right_col[j] = w - 1;
            end
        end
        bound = 0;
        for (int j = 0; j < w; j++) begin
            one = (j < filled) && row_bits[j];
            if (one) begin
                if (col_height[j] < MAX_ROWS) col_height[j]++;
                if (left_col[j] < bound) left_col[j] = bound;
                span = right_col[j] - left_col[j] + 1;
                area = longint'(span) * col_height[j];
                if (area > AREA_LIMIT) area = AREA_LIMIT;
                if (area > best_area) best_area = int'(area);
            end else begin
                col_height[j] = 0;
                bound         = j + 1;
                left_col[j]   = 0;
            end
        end
        if (row_total < MAX_ROWS) row_total++;
        col_fill = 0;
    endfunction

    function automatic void predict_pixel(bit px, bit last);
        int w;
        frame_result_t res;
        w = clamp_width(int'(width_reg));
        if (col_fill < MAX_COLS) begin
            row_bits[col_fill] = px;
            col_fill++;
        end
        if (col_fill >= w) fold_row(w, w);
        if (!last) return;
        if (col_fill > 0) fold_row(w, col_fill);
        res.area = AREA_W'(best_area);
        res.rows = ROWS_W'(row_total);
        expected_areas.push_back(res);
        clear_frame();
    endfunction

    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_areas.size() == 0) begin
                $error("unexpected item: max_area %0d rows_in_frame %0d",
                       m_max_area, m_rows_in_frame);
                errors++;
            end else begin
                want = expected_areas.pop_front();
                if (m_max_area !== want.area) begin
                    $error("max_area: expected %0d, actual %0d", want.area, m_max_area);
                    errors++;
                end
                if (m_rows_in_frame !== want.rows) begin
                    $error("rows_in_frame: expected %0d, actual %0d",
                           want.rows, m_rows_in_frame);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = ready_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (ready_mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    READY_RARELY: m_ready <= ($urandom_range(0, 3) == 0);
                    default:      m_ready <= (cycle_count % 5) > 1;
                endcase
            end
        end
    end

    task automatic send_pixel(input bit px, input bit last);
        int gap;
        gap = 0;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 4);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_pixel         <= px;
        s_last_of_frame <= last;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(px, last);
        items_sent++;
        if (last) frames_sent++;
    endtask

    // Drop valid, drain results, then let any row pass finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_areas.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= ROW_WIDTH_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = ROW_WIDTH_W'(value);
    endtask

    task automatic test_single_pixels();
        steady = 1'b1;
        write_width(1);
        send_pixel(1'b1, 1'b1);
        send_pixel(1'b0, 1'b1);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
        write_width(0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_width_extremes();
        steady = 1'b1;
        write_width(300);
        repeat (MAX_COLS) send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
        write_width(511);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
        write_width(MAX_COLS);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_partial_rows();
        bit [4:0] rows [3];
        steady  = 1'b0;
        rows[0] = 5'b01110;
        rows[1] = 5'b11111;
        rows[2] = 5'b01110;
        write_width(5);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 5; c++) send_pixel(rows[r][c], 1'b0);
        for (int c = 0; c < 3; c++) send_pixel(rows[2][c], c == 2);
        repeat (5) send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_width_change_mid_row();
        steady = 1'b1;
        write_width(8);
        repeat (5) send_pixel(1'b1, 1'b0);
        settle();
        write_width(3);
        send_pixel(1'b0, 1'b0);
        repeat (3) send_pixel(1'b1, 1'b0);
        settle();
        write_width(6);
        repeat (6) send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_tall_frame();
        steady = 1'b0;
        write_width(1);
        repeat (MAX_ROWS + 3) send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_back_pressure();
        int n;
        steady = 1'b1;
        write_width(4);
        hold_req <= hold_req + 1;
        repeat (10) begin
            n = $urandom_range(4, 8);
            for (int k = 0; k < n; k++) send_pixel(1'($urandom_range(0, 1)), k == n - 1);
        end
        settle();
    endtask

    task automatic random_frame(input int w);
        int kind, n, rows, tail, density, total, r, c, r0, r1, c0, c1;
        bit px;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 3 * w);
            if (n > 64) n = 64;
            for (int k = 0; k < n; k++) send_pixel(1'($urandom_range(0, 1)), k == n - 1);
        end else if (kind == 1) begin
            send_pixel(1'($urandom_range(0, 1)), 1'b1);
        end else begin
            rows = (w > 40) ? 0 : $urandom_range(1, 7);
            tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, w) : 0;
            if (w > 40) tail = $urandom_range(1, 48);
            if (rows == 0 && tail == 0) tail = 1;
            case ($urandom_range(0, 2))
                0:       density = 95;
                1:       density = 75;
                default: density = 50;
            endcase
            r0 = $urandom_range(0, rows);
            r1 = $urandom_range(r0, rows);
            c0 = $urandom_range(0, w - 1);
            c1 = $urandom_range(c0, w - 1);
            total = rows * w + tail;
            for (int k = 0; k < total; k++) begin
                r  = k / w;
                c  = k % w;
                px = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ||
                     ($urandom_range(0, 99) < density);
                send_pixel(px, k == total - 1);
            end
        end
    endtask

    task automatic test_random_frames();
        int first_item, first_frame, value;
        first_item  = items_sent;
        first_frame = frames_sent;
        while (items_sent - first_item < RANDOM_ITEMS ||
               frames_sent - first_frame < RANDOM_FRAMES) begin
            case ($urandom_range(0, 19))
                0:          value = 0;
                1:          value = $urandom_range(41, 511);
                2, 3, 4, 5: value = $urandom_range(9, 40);
                default:    value = $urandom_range(1, 8);
            endcase
            write_width(value);
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) random_frame(clamp_width(value));
            settle();
        end
    endtask

    initial begin
        width_reg = ROW_WIDTH_W'(ROW_WIDTH_RESET);
        foreach (row_bits[j]) row_bits[j] = 1'b0;
        clear_frame();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_pixels();
        test_width_extremes();
        test_partial_rows();
        test_width_change_mid_row();
        test_tall_frame();
        test_back_pressure();
        test_random_frames();
        settle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- max_ones_rectangle_area.f -----
+incdir+rtl/core
rtl/core/mora_pkg.sv
rtl/core/mora_row_buf.sv
rtl/core/mora_col_proc.sv
rtl/core/max_ones_rectangle_area.sv
dv/testbench.sv
